### src/spc_pkg.sv
`default_nettype none

package spc_pkg;

    localparam int ModeW = 3;
    localparam int DwellW = 7;
    localparam int AngleW = 8;

    // Mode register codes.
    localparam logic [ModeW-1:0] MODE_STOP   = 3'd0;
    localparam logic [ModeW-1:0] MODE_LEFT   = 3'd1;
    localparam logic [ModeW-1:0] MODE_RIGHT  = 3'd2;
    localparam logic [ModeW-1:0] MODE_SWEEP  = 3'd3;
    localparam logic [ModeW-1:0] MODE_CENTRE = 3'd4;

    // Request type codes.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_DWELL  = 3'd1;
    localparam logic [2:0] REG_LOW    = 3'd2;
    localparam logic [2:0] REG_CENTRE = 3'd3;
    localparam logic [2:0] REG_HIGH   = 3'd4;

    localparam logic [AngleW-1:0] ANGLE_MAX = 8'd180;
    localparam logic [9:0]        SET_LIMIT = 10'sd120;

    localparam logic [ModeW-1:0]  MODE_RESET   = MODE_STOP;
    localparam logic [DwellW-1:0] DWELL_RESET  = 7'd80;
    localparam logic [AngleW-1:0] LOW_RESET    = 8'd5;
    localparam logic [AngleW-1:0] CENTRE_RESET = 8'd60;
    localparam logic [AngleW-1:0] HIGH_RESET   = 8'd115;

    typedef struct packed {
        logic [ModeW-1:0]  mode;
        logic [DwellW-1:0] dwell_ticks;
        logic [AngleW-1:0] low_end;
        logic [AngleW-1:0] centre_angle;
        logic [AngleW-1:0] high_end;
    } cfg_t;

    typedef struct packed {
        logic [AngleW-1:0] angle;
        logic [DwellW-1:0] dwell_count;
        logic              sweep_up;
    } state_t;

    typedef struct packed {
        logic [AngleW-1:0]        servo_angle;
        logic signed [AngleW-1:0] angle_offset;
        logic                     servo_written;
    } result_t;

endpackage

`default_nettype wire

### src/spc_cfg_regs.sv
`default_nettype none

module spc_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output spc_pkg::cfg_t      cfg
);
    import spc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_MODE:   cfg_next.mode         = pwdata[ModeW-1:0];
                REG_DWELL:  cfg_next.dwell_ticks  = pwdata[DwellW-1:0];
                REG_LOW:    cfg_next.low_end      = pwdata[AngleW-1:0];
                REG_CENTRE: cfg_next.centre_angle = pwdata[AngleW-1:0];
                REG_HIGH:   cfg_next.high_end     = pwdata[AngleW-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:   prdata = {29'd0, cfg_reg.mode};
            REG_DWELL:  prdata = {25'd0, cfg_reg.dwell_ticks};
            REG_LOW:    prdata = {24'd0, cfg_reg.low_end};
            REG_CENTRE: prdata = {24'd0, cfg_reg.centre_angle};
            REG_HIGH:   prdata = {24'd0, cfg_reg.high_end};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= MODE_RESET;
            cfg_reg.dwell_ticks  <= DWELL_RESET;
            cfg_reg.low_end      <= LOW_RESET;
            cfg_reg.centre_angle <= CENTRE_RESET;
            cfg_reg.high_end     <= HIGH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### src/spc_core.sv
`default_nettype none

module spc_core (
    input  wire spc_pkg::cfg_t   cfg,
    input  wire spc_pkg::state_t state,
    input  wire logic            req_type,
    input  wire logic [7:0]      angle_request,
    output spc_pkg::state_t      state_next,
    output spc_pkg::result_t     result
);
    import spc_pkg::*;

    logic [AngleW-1:0]  ang_up;
    logic [AngleW-1:0]  ang_dn;
    logic signed [9:0]  target;
    logic               target_ok;
    logic               at_low;
    logic               at_centre;
    logic               at_high;
    logic [DwellW-1:0]  dwell_inc;
    logic               dir_next;
    logic signed [9:0]  diff;
    logic               written;

    // Single-degree steps, saturated to the servo's range.
    assign ang_up = (state.angle >= ANGLE_MAX) ? ANGLE_MAX : state.angle + 8'd1;
    assign ang_dn = (state.angle == 8'd0) ? 8'd0 :
                    (state.angle > ANGLE_MAX + 8'd1) ? ANGLE_MAX : state.angle - 8'd1;

    assign target    = $signed({{2{angle_request[7]}}, angle_request})
                     + $signed({2'b00, cfg.centre_angle});
    assign target_ok = (target > 10'sd0) && (target < $signed(SET_LIMIT));

    assign at_low    = (state.angle == cfg.low_end);
    assign at_centre = !at_low && (state.angle == cfg.centre_angle);
    assign at_high   = !at_low && !at_centre && (state.angle == cfg.high_end);
    assign dwell_inc = state.dwell_count + 7'd1;
    assign dir_next  = (at_low || at_high) ? !state.sweep_up : state.sweep_up;

    always_comb
    begin
        state_next = state;
        written    = 1'b0;
        if (req_type == REQ_SET)
        begin
            if (target_ok)
            begin
                state_next.angle = target[7:0];
                written          = 1'b1;
            end
        end
        else
        begin
            unique case (cfg.mode)
                MODE_LEFT:
                begin
                    if (state.angle < cfg.high_end)
                    begin
                        state_next.angle = ang_up;
                        written          = 1'b1;
                    end
                end
                MODE_RIGHT:
                begin
                    if (state.angle > cfg.low_end)
                    begin
                        state_next.angle = ang_dn;
                        written          = 1'b1;
                    end
                end
                MODE_SWEEP:
                begin
                    if (at_low || at_centre || at_high)
                    begin
                        if (dwell_inc < cfg.dwell_ticks)
                        begin
                            state_next.dwell_count = dwell_inc;
                        end
                        else
                        begin
                            state_next.dwell_count = '0;
                            state_next.sweep_up    = dir_next;
                            state_next.angle       = dir_next ? ang_up : ang_dn;
                            written                = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next.angle = state.sweep_up ? ang_up : ang_dn;
                        written          = 1'b1;
                    end
                end
                MODE_CENTRE:
                begin
                    state_next.angle = cfg.centre_angle;
                    written          = 1'b1;
                end
                default:
                begin
                    state_next = state;
                end
            endcase
        end
    end

    // Offset from centre, clamped to the signed 8-bit range.
    assign diff = $signed({2'b00, state_next.angle}) - $signed({2'b00, cfg.centre_angle});

    always_comb
    begin
        result.servo_angle   = state_next.angle;
        result.servo_written = written;
        priority if (diff > 10'sd127)
            result.angle_offset = 8'sd127;
        else if (diff < -10'sd128)
            result.angle_offset = -8'sd128;
        else
            result.angle_offset = diff[7:0];
    end

endmodule

`default_nettype wire

### src/servo_pan_sweep_controller.sv
// Servo pan sweep controller.
// Input channel: in_valid/in_stall carry one beat per item, either a tick
// (req_type 0) that advances the angle by the mode register, or a set-angle
// request (req_type 1) whose angle_request is an offset from centre.
// Output channel: out_valid/out_stall carry one result beat per item with
// servo_angle, angle_offset and servo_written.
// An accepted beat lands in an input register; once the result register can take
// it, the per-item update runs through one combinational stage into the result
// register and the angle, dwell counter and sweep direction are updated together.
// A new beat can be taken every cycle while the receiver does not stall: one item
// per cycle sustained.
// When the receiver stalls, the result register holds its beat, the input
// register keeps its item, and in_stall rises once both are full.
// Configuration goes through the APB-style port (registers at 4*i) and must
// only be changed while no item is in flight.
// Reset clears both stages and restores angle 60, dwell count 0, sweep
// moving down, and the register defaults.
`default_nettype none

module servo_pan_sweep_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [7:0]  angle_request,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       servo_angle,
    output logic signed [7:0] angle_offset,
    output logic             servo_written
);
    import spc_pkg::*;

    cfg_t        cfg;
    state_t      state_reg;
    state_t      state_calc;
    result_t     result_calc;
    result_t     res_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_req_reg;
    logic [7:0]  s1_angle_req_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_ready;
    logic        advance;
    logic        in_take;

    spc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spc_core u_core (
        .cfg           (cfg),
        .state         (state_reg),
        .req_type      (s1_req_reg),
        .angle_request (s1_angle_req_reg),
        .state_next    (state_calc),
        .result        (result_calc)
    );

    // The result register can take a new beat when it is empty or being drained.
    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.angle       <= CENTRE_RESET;
            state_reg.dwell_count <= '0;
            state_reg.sweep_up    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_calc;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_req_reg       <= req_type;
            s1_angle_req_reg <= angle_request;
        end
        if (advance)
            res_reg <= result_calc;
    end

    assign out_valid     = out_valid_reg;
    assign servo_angle   = res_reg.servo_angle;
    assign angle_offset  = res_reg.angle_offset;
    assign servo_written = res_reg.servo_written;

    // A buffered item that cannot move on must still be there next cycle.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_ready) |=> s1_valid_reg)
        else $error("input stage lost an item while the output was stalled");

    // An item that reports no servo write leaves the angle untouched.
    a_no_write_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !result_calc.servo_written) |=> (state_reg.angle == $past(state_reg.angle)))
        else $error("angle changed without a servo write");

    // The reported angle is the angle the state now holds.
    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (res_reg.servo_angle == state_reg.angle))
        else $error("result angle differs from stored angle");

endmodule

`default_nettype wire

### verif/servo_pan_sweep_controller_chk.sv
module servo_pan_sweep_controller_chk (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              req_type,
    input  logic [7:0]        angle_request,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [7:0]        servo_angle,
    input  logic signed [7:0] angle_offset,
    input  logic              servo_written,
    output int                fail_count,
    output int                pending,
    output int                results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import spc_pkg::*;

    cfg_t    regs;
    state_t  st;
    result_t expected_servo[$];
    result_t want;
    int      mism;
    int      seen;

    // One degree toward the requested side, held inside 0..180.
    function automatic logic [AngleW-1:0] nudge(input logic [AngleW-1:0] a, input logic up);
        if (up)
            return (a >= ANGLE_MAX) ? ANGLE_MAX : a + 8'd1;
        if (a == '0)
            return '0;
        return (int'(a) > int'(ANGLE_MAX) + 1) ? ANGLE_MAX : a - 8'd1;
    endfunction

    // Applies one item to the shadow state and returns the result it should produce.
    function automatic result_t servo_update(input logic rt, input logic [AngleW-1:0] ar);
        int      tgt;
        int      diff;
        logic    at_low;
        logic    at_mid;
        logic    at_high;
        result_t r;
        r.servo_written = 1'b0;
        if (rt == REQ_SET)
        begin
            tgt = int'($signed(ar)) + int'(regs.centre_angle);
            if (tgt > 0 && tgt < int'(SET_LIMIT))
            begin
                st.angle = tgt[AngleW-1:0];
                r.servo_written = 1'b1;
            end
        end
        else
        begin
            case (regs.mode)
                MODE_LEFT:
                begin
                    if (st.angle < regs.high_end)
                    begin
                        st.angle = nudge(st.angle, 1'b1);
                        r.servo_written = 1'b1;
                    end
                end
                MODE_RIGHT:
                begin
                    if (st.angle > regs.low_end)
                    begin
                        st.angle = nudge(st.angle, 1'b0);
                        r.servo_written = 1'b1;
                    end
                end
                MODE_SWEEP:
                begin
                    at_low  = (st.angle == regs.low_end);
                    at_mid  = !at_low && (st.angle == regs.centre_angle);
                    at_high = !at_low && !at_mid && (st.angle == regs.high_end);
                    r.servo_written = 1'b1;
                    if (at_low || at_mid || at_high)
                    begin
                        st.dwell_count = st.dwell_count + 1'b1;
                        if (st.dwell_count < regs.dwell_ticks)
                        begin
                            r.servo_written = 1'b0;
                        end
                        else
                        begin
                            st.dwell_count = '0;
                            if (!at_mid)
                                st.sweep_up = !st.sweep_up;
                        end
                    end
                    if (r.servo_written)
                        st.angle = nudge(st.angle, st.sweep_up);
                end
                MODE_CENTRE:
                begin
                    st.angle = regs.centre_angle;
                    r.servo_written = 1'b1;
                end
                default: ;
            endcase
        end
        diff = int'(st.angle) - int'(regs.centre_angle);
        if (diff > 127)
            diff = 127;
        if (diff < -128)
            diff = -128;
        r.servo_angle  = st.angle;
        r.angle_offset = diff[AngleW-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.mode         = MODE_RESET;
            regs.dwell_ticks  = DWELL_RESET;
            regs.low_end      = LOW_RESET;
            regs.centre_angle = CENTRE_RESET;
            regs.high_end     = HIGH_RESET;
            st.angle          = CENTRE_RESET;
            st.dwell_count    = '0;
            st.sweep_up       = 1'b0;
            expected_servo.delete();
            mism = 0;
            seen = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_MODE:   regs.mode         = pwdata[ModeW-1:0];
                    REG_DWELL:  regs.dwell_ticks  = pwdata[DwellW-1:0];
                    REG_LOW:    regs.low_end      = pwdata[AngleW-1:0];
                    REG_CENTRE: regs.centre_angle = pwdata[AngleW-1:0];
                    REG_HIGH:   regs.high_end     = pwdata[AngleW-1:0];
                    default: ;
                endcase
            end
            // The result beat leaving at this edge belongs to an earlier item, so it is
            // compared before this edge's input beat is predicted.
            if (out_valid && !out_stall)
            begin
                if (expected_servo.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, angle %0d",
                             $time, servo_angle);
                    mism++;
                end
                else
                begin
                    want = expected_servo.pop_front();
                    seen++;
                    if (servo_angle !== want.servo_angle)
                    begin
                        $display("%0t: servo_angle expected %0d actual %0d",
                                 $time, want.servo_angle, servo_angle);
                        mism++;
                    end
                    if (angle_offset !== want.angle_offset)
                    begin
                        $display("%0t: angle_offset expected %0d actual %0d",
                                 $time, want.angle_offset, angle_offset);
                        mism++;
                    end
                    if (servo_written !== want.servo_written)
                    begin
                        $display("%0t: servo_written expected %0d actual %0d",
                                 $time, want.servo_written, servo_written);
                        mism++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_servo.push_back(servo_update(req_type, angle_request));
        end
        fail_count   <= mism;
        pending      <= expected_servo.size();
        results_seen <= seen;
    end

endmodule

### verif/servo_pan_sweep_controller_tb.sv
module servo_pan_sweep_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spc_pkg::*;

    // Clock, reset and every block input start at a known value.
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [4:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              req_type = REQ_TICK;
    logic [7:0]        angle_request = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [7:0]        servo_angle;
    logic signed [7:0] angle_offset;
    logic              servo_written;

    // Verdict inputs from the checker.
    int fail_count;
    int pending;
    int results_seen;

    // Run bookkeeping for the summary line.
    int beats_sent = 0;
    int set_beats = 0;
    int phases = 0;

    // While calm is set, neither the sender nor the receiver ever pauses.
    bit calm = 1'b0;

    servo_pan_sweep_controller DUT (.*);

    servo_pan_sweep_controller_chk checker_i (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The receiver stalls at random about 12 percent of the time, except in the calm stretch.
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 12);
    end

    // Offers one item beat and returns at the edge that accepts it. A random idle
    // gap of whole clock periods may come first, so valid never drops and rises again
    // within the same time step. The payload is held while the beat is stalled.
    task automatic send_beat(input logic rt, input logic [7:0] ar);
        while (!calm && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= rt;
        angle_request <= ar;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
        if (rt == REQ_SET)
            set_beats++;
    endtask

    // Waits until every predicted result has been seen. The first edge lets the
    // checker count the beat accepted at the previous edge; the wait after that
    // covers the two-stage pipeline.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write: setup cycle, then the access cycle, which writes at the
    // following edge since pready is always high. The select is left up so that
    // back-to-back writes never change it twice in one step.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    // Loads a whole register setting once the block has gone idle.
    task automatic tune(input logic [ModeW-1:0] md, input logic [DwellW-1:0] dw,
                        input logic [AngleW-1:0] lo, input logic [AngleW-1:0] ce,
                        input logic [AngleW-1:0] hi);
        settle();
        write_reg(REG_MODE, 32'(md));
        write_reg(REG_DWELL, 32'(dw));
        write_reg(REG_LOW, 32'(lo));
        write_reg(REG_CENTRE, 32'(ce));
        write_reg(REG_HIGH, 32'(hi));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        phases++;
    endtask

    initial
    begin
        int pick;
        int ce;
        int lo;
        int hi;
        int dw;
        int off;
        logic [ModeW-1:0] md;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting from the reset setting (stop, centre 60).
        // Offset extremes, then the edges of the set-angle window: a target of 0 or
        // 120 is refused, 1 and 119 are taken.
        send_beat(REQ_SET, 8'h80);
        send_beat(REQ_SET, 8'h7f);
        send_beat(REQ_SET, 8'(-60));
        send_beat(REQ_SET, 8'(-59));
        send_beat(REQ_SET, 8'd59);
        send_beat(REQ_SET, 8'd60);
        send_beat(REQ_TICK, 8'hff);

        // Reset to centre with the centre above the servo range, then step down from
        // there (saturates to 180) and step up at 180 (stays at 180, still written).
        tune(MODE_CENTRE, 7'd1, 8'd0, 8'd200, 8'd255);
        send_beat(REQ_TICK, 8'h00);
        tune(MODE_RIGHT, 7'd1, 8'd0, 8'd200, 8'd255);
        send_beat(REQ_TICK, 8'h55);
        tune(MODE_LEFT, 7'd1, 8'd0, 8'd200, 8'd255);
        send_beat(REQ_TICK, 8'haa);

        // Steps at the limits do nothing; with centre 0 the offset of 180 clips to 127.
        tune(MODE_LEFT, 7'd1, 8'd0, 8'd0, 8'd180);
        send_beat(REQ_TICK, 8'h01);
        tune(MODE_RIGHT, 7'd1, 8'd180, 8'd0, 8'd255);
        send_beat(REQ_TICK, 8'h02);

        // The unused mode codes behave like stop.
        for (int m = MODE_CENTRE + 1; m < 8; m++)
        begin
            tune(3'(m), 7'd1, 8'd0, 8'd0, 8'd255);
            send_beat(REQ_TICK, 8'(m));
        end

        // A tight sweep from the centre: dwell, turn at each end point, dwell again.
        tune(MODE_SWEEP, 7'd2, 8'd58, 8'd60, 8'd62);
        send_beat(REQ_SET, 8'd0);
        repeat (10) send_beat(REQ_TICK, 8'($urandom_range(255)));

        // A centre far above the angle clips the offset to -128.
        tune(MODE_STOP, 7'd2, 8'd58, 8'd200, 8'd62);
        send_beat(REQ_TICK, 8'h3c);

        // Random part. Most settings are narrow bands around the centre so sweeps
        // actually reach their dwell points and turn around; the rest are step,
        // centre and fully random settings. Phases 12 to 15 run with no pauses.
        for (int ph = 0; ph < 28; ph++)
        begin
            calm = (ph >= 12 && ph < 16);
            pick = $urandom_range(9);
            ce = $urandom_range(20, 100);
            lo = ce - int'($urandom_range(1, 8));
            hi = ce + int'($urandom_range(1, 8));
            dw = $urandom_range(1, 4);
            if (pick < 5)
                md = MODE_SWEEP;
            else if (pick < 8)
                md = pick[0] ? MODE_LEFT : MODE_RIGHT;
            else if (pick == 8)
                md = MODE_CENTRE;
            else
            begin
                md = 3'($urandom_range(7));
                dw = $urandom_range(127);
                lo = $urandom_range(255);
                ce = $urandom_range(255);
                hi = $urandom_range(255);
            end
            // The dwell register extremes get a phase each.
            if (ph == 0)
                dw = 0;
            if (ph == 1)
                dw = 127;
            tune(md, dw[DwellW-1:0], lo[AngleW-1:0], ce[AngleW-1:0], hi[AngleW-1:0]);

            // Put the servo inside the band before ticking.
            if (pick < 9)
            begin
                off = $urandom_range(lo, hi);
                send_beat(REQ_SET, 8'(off - ce));
            end

            repeat (26)
            begin
                if ($urandom_range(99) < 12)
                begin
                    if ($urandom_range(1))
                        off = $urandom_range(255);
                    else
                    begin
                        off = $urandom_range(lo, hi);
                        off = off - ce;
                    end
                    send_beat(REQ_SET, 8'(off));
                end
                else
                    send_beat(REQ_TICK, 8'($urandom_range(255)));
            end
        end

        calm = 1'b0;
        settle();

        $display("summary: %0d item beats (%0d set-angle) over %0d register settings",
                 beats_sent, set_beats, phases);
        $display("summary: %0d result beats compared field by field", results_seen);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule

### servo_pan_sweep_controller.f
src/spc_pkg.sv
src/spc_cfg_regs.sv
src/spc_core.sv
src/servo_pan_sweep_controller.sv
verif/servo_pan_sweep_controller_chk.sv
verif/servo_pan_sweep_controller_tb.sv
